// File: hdl/mfw_pkg.sv
// Shared widths, register indexes and pipeline types for the fold/wrap shaper.
`timescale 1ns / 1ps
package mfw_pkg;
    localparam int VW = 17;
    localparam int TW = 14;
    localparam int MW = 18;
    localparam int PW = 13;
    localparam int IW = 3;
    localparam int RW = 22;
    localparam int LAT = 20 + RW;

    localparam logic signed [VW-1:0] VOLT_LIMIT = 17'sd40960;
    localparam int DEGEN_SPAN = 4;
    localparam int MIX_LIMIT = 81920;
    localparam int NORM_LOW = -20480;
    localparam int NORM_HIGH = 40960;

    localparam logic [IW-1:0] REG_OFFSET = 3'd0;
    localparam logic [IW-1:0] REG_LOW_CUT = 3'd1;
    localparam logic [IW-1:0] REG_HIGH_CUT = 3'd2;
    localparam logic [IW-1:0] REG_LOW_TRIM = 3'd3;
    localparam logic [IW-1:0] REG_HIGH_TRIM = 3'd4;
    localparam logic [IW-1:0] REG_MODE = 3'd5;
    localparam logic [IW-1:0] REG_LEVEL = 3'd6;

    typedef struct packed {
        logic signed [19:0] low;
        logic signed [20:0] span;
        logic signed [VW-1:0] lvl;
        logic degen;
    } t_side;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dvd;
        logic [RW-1:0] modv;
        logic [RW-1:0] d;
        logic neg;
        t_side side;
    } t_mod;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [PW-1:0] dvd;
        logic [RW-1:0] dv;
        logic [PW-1:0] quo;
        t_side side;
    } t_div;
endpackage

// File: hdl/mix_fold_wrap_shaper_unit.sv
// Top level: mix, fold or wrap, and rescale pipeline with its register file.
`timescale 1ns / 1ps
// One word enters per clock whenever start is high; busy stays low. Each result
// appears on the o_ result ports for one cycle under o_valid, after the 22-step
// remainder pipeline and the 13-step phase divider. Results must be taken as they
// come. Register writes take effect at once and belong to idle periods.
module mix_fold_wrap_shaper_unit
    import mfw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [IW-1:0]        i_cfg_idx,
    input  logic [VW-1:0]        i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [VW-1:0] i_in_one,
    input  logic signed [VW-1:0] i_in_two,
    input  logic signed [VW-1:0] i_in_three,
    input  logic signed [VW-1:0] i_low_mod,
    input  logic signed [VW-1:0] i_high_mod,
    input  logic signed [VW-1:0] i_level_mod,
    output logic                 o_valid,
    output logic signed [MW-1:0] o_mix_out,
    output logic signed [VW-1:0] o_norm_out,
    output logic [PW-1:0]        o_phase,
    output logic                 o_bounds_degenerate
);
    logic signed [VW-1:0] r_offset, r_low_cut, r_high_cut, r_level;
    logic signed [TW-1:0] r_low_trim, r_high_trim;
    logic                 r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_low_cut <= -17'sd20480;
            r_high_cut <= 17'sd20480;
            r_low_trim <= '0;
            r_high_trim <= '0;
            r_mode <= 1'b0;
            r_level <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_LOW_CUT: r_low_cut <= i_cfg_data;
                REG_HIGH_CUT: r_high_cut <= i_cfg_data;
                REG_LOW_TRIM: r_low_trim <= i_cfg_data[TW-1:0];
                REG_HIGH_TRIM: r_high_trim <= i_cfg_data[TW-1:0];
                REG_MODE: r_mode <= i_cfg_data[0];
                REG_LEVEL: r_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    function automatic logic signed [VW-1:0] clamp_cv(input logic signed [VW-1:0] v);
        if (v > VOLT_LIMIT) return VOLT_LIMIT;
        if (v < -VOLT_LIMIT) return -VOLT_LIMIT;
        return v;
    endfunction

    function automatic t_mod mod_step(input t_mod x);
        logic [RW:0] t;
        t_mod        y;
        t = {x.rem, x.dvd[RW-1]};
        y = x;
        y.dvd = {x.dvd[RW-2:0], 1'b0};
        if (t >= {1'b0, x.modv}) y.rem = RW'(t - {1'b0, x.modv});
        else y.rem = t[RW-1:0];
        return y;
    endfunction

    function automatic t_div div_step(input t_div x);
        logic [RW:0] t;
        t_div        y;
        t = {x.rem, x.dvd[PW-1]};
        y = x;
        y.dvd = {x.dvd[PW-2:0], 1'b0};
        if (t >= {1'b0, x.dv}) begin
            y.rem = RW'(t - {1'b0, x.dv});
            y.quo = {x.quo[PW-2:0], 1'b1};
        end else begin
            y.rem = t[RW-1:0];
            y.quo = {x.quo[PW-2:0], 1'b0};
        end
        return y;
    endfunction

    // stage 1: mix sum, trim products, level
    logic                 r_v1;
    logic signed [18:0]   r1_mix;
    logic signed [30:0]   r1_pl, r1_ph;
    logic signed [VW-1:0] r1_lvl;
    logic signed [VW:0]   n_lvl_sum;

    always_comb begin
        n_lvl_sum = VW'(0) + 18'(r_level) + 18'(clamp_cv(i_level_mod));
        if (n_lvl_sum > 18'sd40960) n_lvl_sum = 18'sd40960;
        else if (n_lvl_sum < -18'sd40960) n_lvl_sum = -18'sd40960;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= start;
        r1_mix <= 19'(i_in_one) + 19'(i_in_two) + 19'(i_in_three) + 19'(r_offset);
        r1_pl <= 31'(r_low_trim) * 31'(clamp_cv(i_low_mod));
        r1_ph <= 31'(r_high_trim) * 31'(clamp_cv(i_high_mod));
        r1_lvl <= n_lvl_sum[VW-1:0];
    end

    // stage 2: bounds
    logic                 r_v2;
    logic signed [18:0]   r2_mix;
    logic signed [19:0]   r2_low, r2_high;
    logic signed [VW-1:0] r2_lvl;
    logic signed [31:0]   n_pl, n_ph;

    assign n_pl = 32'(r1_pl) + 32'sd2048;
    assign n_ph = 32'(r1_ph) + 32'sd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
        r2_mix <= r1_mix;
        r2_low <= 20'(r_low_cut) + n_pl[31:12];
        r2_high <= 20'(r_high_cut) + n_ph[31:12];
        r2_lvl <= r1_lvl;
    end

    // stage 3: span, degenerate test, signed position numerator
    logic                 r_v3;
    t_side                r3_side;
    logic signed [RW-1:0] r3_n;
    logic [RW-1:0]        r3_d;
    logic signed [20:0]   n_span;
    logic signed [RW-1:0] n_num;

    assign n_span = 21'(r2_high) - 21'(r2_low);
    assign n_num = RW'(r2_mix) - RW'(r2_low);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_v2;
        r3_side.low <= r2_low;
        r3_side.span <= n_span;
        r3_side.lvl <= r2_lvl;
        r3_side.degen <= (n_span <= 21'sd4) && (n_span >= -21'sd4);
        r3_n <= n_span[20] ? -n_num : n_num;
        r3_d <= n_span[20] ? RW'(-n_span) : RW'(n_span);
    end

    // stage 4: dividend and modulus for the remainder pipeline
    logic                 r_v4;
    t_mod                 r4;
    logic signed [RW-1:0] n_a;

    assign n_a = r_mode ? r3_n : r3_n + $signed(r3_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else r_v4 <= r_v3;
        r4.rem <= '0;
        r4.dvd <= n_a[RW-1] ? RW'(-n_a) : RW'(n_a);
        r4.modv <= r_mode ? r3_d : {r3_d[RW-2:0], 1'b0};
        r4.d <= r3_d;
        r4.neg <= n_a[RW-1];
        r4.side <= r3_side;
    end

    // remainder pipeline: one dividend bit a stage
    logic [RW:1]   r_vm;
    t_mod          r_md [1:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vm <= '0;
        else r_vm <= {r_vm[RW-1:1], r_v4};
        r_md[1] <= mod_step(r4);
        for (int k = 1; k < RW; k++) begin
            r_md[k+1] <= mod_step(r_md[k]);
        end
    end

    // stage 5: floor remainder, fold, divider setup
    logic          r_v5;
    t_div          r5;
    t_mod          w_mf;
    logic [RW-1:0] n_r, n_m;

    assign w_mf = r_md[RW];

    always_comb begin
        n_r = (w_mf.neg && w_mf.rem != '0) ? w_mf.modv - w_mf.rem : w_mf.rem;
        if (r_mode) n_m = n_r;
        else n_m = (n_r >= w_mf.d) ? n_r - w_mf.d : w_mf.d - n_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else r_v5 <= r_vm[RW];
        r5.rem <= n_m + (w_mf.d >> PW);
        r5.dvd <= w_mf.d[PW-1:0];
        r5.dv <= {w_mf.d[RW-2:0], 1'b0};
        r5.quo <= '0;
        r5.side <= w_mf.side;
    end

    // phase divider: one quotient bit a stage
    logic [PW:1] r_vd;
    t_div        r_dv [1:PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= '0;
        else r_vd <= {r_vd[PW-1:1], r_v5};
        r_dv[1] <= div_step(r5);
        for (int k = 1; k < PW; k++) begin
            r_dv[k+1] <= div_step(r_dv[k]);
        end
    end

    // stage 6: rescale products
    logic                 r_v6;
    t_side                r6_side;
    logic [PW-1:0]        r6_phase;
    logic signed [34:0]   r6_pm;
    logic [28:0]          r6_pn;
    t_side                w_ds;
    logic [PW-1:0]        n_phase;
    logic [15:0]          n_alvl;

    assign w_ds = r_dv[PW].side;
    assign n_phase = w_ds.degen ? '0 : r_dv[PW].quo;
    assign n_alvl = w_ds.lvl[VW-1] ? 16'(-w_ds.lvl) : 16'(w_ds.lvl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else r_v6 <= r_vd[PW];
        r6_side <= w_ds;
        r6_phase <= n_phase;
        r6_pm <= $signed({22'd0, n_phase}) * 35'(w_ds.span);
        r6_pn <= 29'(n_phase) * 29'(n_alvl);
    end

    // stage 7: round, saturate, drive the result word
    logic signed [34:0] n_pm;
    logic signed [23:0] n_mix;
    logic signed [31:0] n_ns;
    logic signed [18:0] n_norm;

    always_comb begin
        n_pm = r6_pm + 35'sd2048;
        n_mix = 24'($signed(n_pm[34:12])) + 24'(r6_side.low);
        n_ns = $signed({2'b00, r6_pn, 1'b0}) + 32'sd4096
             + (r6_side.lvl[VW-1] ? $signed({{3{r6_side.lvl[VW-1]}}, r6_side.lvl, 12'd0})
                                  : 32'sd0);
        n_norm = n_ns[31:13];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v6;
        if (n_mix > 24'(MIX_LIMIT)) o_mix_out <= MW'(MIX_LIMIT);
        else if (n_mix < -24'(MIX_LIMIT)) o_mix_out <= MW'(-MIX_LIMIT);
        else o_mix_out <= n_mix[MW-1:0];
        if (n_norm > 19'(NORM_HIGH)) o_norm_out <= VW'(NORM_HIGH);
        else if (n_norm < 19'(NORM_LOW)) o_norm_out <= VW'(NORM_LOW);
        else o_norm_out <= n_norm[VW-1:0];
        o_phase <= r6_phase;
        o_bounds_degenerate <= r6_side.degen;
    end
endmodule

// File: hdl/mfw_chk.sv
// Port-level checker for the fold/wrap shaper and its bind.
`timescale 1ns / 1ps
module mfw_chk
    import mfw_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input logic [PW-1:0] o_phase,
    input logic          o_bounds_degenerate
);
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid) else $error("word lost");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LAT !o_valid) else $error("word invented");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bounds_degenerate |-> o_phase == '0) else $error("degenerate phase");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_phase <= PW'(4096)) else $error("phase range");
endmodule

bind mix_fold_wrap_shaper_unit mfw_chk u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_valid(o_valid),
    .o_phase(o_phase),
    .o_bounds_degenerate(o_bounds_degenerate)
);

// File: tb/tb_mix_fold_wrap_shaper_unit.sv
// Self-checking testbench for the fold/wrap shaper: random and directed samples vs a predictor.
`timescale 1ns / 1ps
module tb_mix_fold_wrap_shaper_unit;
    import mfw_pkg::*;

    typedef struct {
        longint mix_out;
        longint norm_out;
        longint phase;
        longint degen;
    } t_shape;

    class shaper_scoreboard;
        longint regs[7];
        t_shape pending[$];
        int errors;
        int checked;

        function new();
            errors = 0;
            checked = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            regs[REG_OFFSET] = 0;
            regs[REG_LOW_CUT] = -20480;
            regs[REG_HIGH_CUT] = 20480;
            regs[REG_LOW_TRIM] = 0;
            regs[REG_HIGH_TRIM] = 0;
            regs[REG_MODE] = 0;
            regs[REG_LEVEL] = 0;
        endfunction

        function longint sx(longint v, int w);
            longint m;
            m = (longint'(1) << w) - 1;
            v = v & m;
            if (v[w-1]) v = v - (longint'(1) << w);
            return v;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint pos_mod(longint a, longint b);
            longint r;
            r = a % b;
            return r < 0 ? r + b : r;
        endfunction

        function void write_reg(int idx, longint val);
            if (idx >= 7) return;
            if (idx == REG_MODE) regs[idx] = val & 1;
            else if (idx == REG_LOW_TRIM || idx == REG_HIGH_TRIM) regs[idx] = sx(val, TW);
            else regs[idx] = sx(val, VW);
        endfunction

        function void note_sample(longint a, longint b, longint c, longint lm, longint hm,
                                  longint nm);
            t_shape r;
            longint mix, lcv, hcv, ncv, lo, hi, span, ph, n, d, m, lvl, alvl, nv, mo;
            bit dg;
            mix = a + b + c + regs[REG_OFFSET];
            lcv = clip(lm, -40960, 40960);
            hcv = clip(hm, -40960, 40960);
            ncv = clip(nm, -40960, 40960);
            lo = regs[REG_LOW_CUT] + floor_div(regs[REG_LOW_TRIM] * lcv + 2048, 4096);
            hi = regs[REG_HIGH_CUT] + floor_div(regs[REG_HIGH_TRIM] * hcv + 2048, 4096);
            span = hi - lo;
            ph = 0;
            dg = (span <= 4 && span >= -4);
            if (!dg) begin
                n = mix - lo;
                d = span;
                if (d < 0) begin
                    n = -n;
                    d = -d;
                end
                if (regs[REG_MODE] == 0) begin
                    m = pos_mod(n + d, 2 * d) - d;
                    if (m < 0) m = -m;
                end else begin
                    m = pos_mod(n, d);
                end
                ph = (m * 2 * 4096 + d) / (2 * d);
            end
            mo = clip(lo + floor_div(ph * span + 2048, 4096), -81920, 81920);
            lvl = clip(regs[REG_LEVEL] + ncv, -40960, 40960);
            alvl = lvl < 0 ? -lvl : lvl;
            nv = 2 * ph * alvl + (lvl < 0 ? 4096 * lvl : 0);
            nv = clip(floor_div(nv + 4096, 8192), -20480, 40960);
            r.mix_out = mo;
            r.norm_out = nv;
            r.phase = ph;
            r.degen = dg;
            pending.push_back(r);
        endfunction

        function void check_result(longint mo, longint nv, longint ph, longint dg);
            t_shape e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word mix %0d norm %0d phase %0d", $time, mo, nv, ph);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.mix_out != mo) begin
                $display("%0t: mix_out expected %0d actual %0d", $time, e.mix_out, mo);
                errors++;
            end
            if (e.norm_out != nv) begin
                $display("%0t: norm_out expected %0d actual %0d", $time, e.norm_out, nv);
                errors++;
            end
            if (e.phase != ph) begin
                $display("%0t: phase expected %0d actual %0d", $time, e.phase, ph);
                errors++;
            end
            if (e.degen != dg) begin
                $display("%0t: bounds_degenerate expected %0d actual %0d", $time, e.degen, dg);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_wr = 0;
    logic [IW-1:0]        i_cfg_idx = '0;
    logic [VW-1:0]        i_cfg_data = '0;
    logic                 start = 0;
    logic                 busy;
    logic signed [VW-1:0] i_in_one = '0;
    logic signed [VW-1:0] i_in_two = '0;
    logic signed [VW-1:0] i_in_three = '0;
    logic signed [VW-1:0] i_low_mod = '0;
    logic signed [VW-1:0] i_high_mod = '0;
    logic signed [VW-1:0] i_level_mod = '0;
    logic                 o_valid;
    logic signed [MW-1:0] o_mix_out;
    logic signed [VW-1:0] o_norm_out;
    logic [PW-1:0]        o_phase;
    logic                 o_bounds_degenerate;

    shaper_scoreboard sb;
    int idle_pct;
    int stall_cycles;
    int n_samples;
    int i;
    int k;

    mix_fold_wrap_shaper_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) stall_cycles <= 0;
            else if (o_valid) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (o_valid)
                sb.check_result(o_mix_out, o_norm_out, o_phase, o_bounds_degenerate);
            if (stall_cycles > 5000) begin
                $display("%0t: watchdog expired", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic cfg_write(input int idx, input longint val);
        @(negedge i_clk);
        i_cfg_wr = 1;
        i_cfg_idx = idx[IW-1:0];
        i_cfg_data = val[VW-1:0];
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr = 0;
    endtask

    task automatic send_word(input longint a, input longint b, input longint c,
                             input longint lm, input longint hm, input longint nm);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_in_one <= a[VW-1:0];
        i_in_two <= b[VW-1:0];
        i_in_three <= c[VW-1:0];
        i_low_mod <= lm[VW-1:0];
        i_high_mod <= hm[VW-1:0];
        i_level_mod <= nm[VW-1:0];
        do @(posedge i_clk); while (busy);
        sb.note_sample(sb.sx(a, VW), sb.sx(b, VW), sb.sx(c, VW), sb.sx(lm, VW),
                       sb.sx(hm, VW), sb.sx(nm, VW));
        n_samples++;
        @(negedge i_clk);
    endtask

    function automatic longint rv();
        int s;
        s = $urandom_range(9);
        if (s == 0) return $urandom_range(1) ? 40960 : -40960;
        if (s == 1) return longint'($urandom_range(131071)) - 65536;
        if (s < 5) return longint'($urandom_range(8192)) - 4096;
        return longint'($urandom_range(81920)) - 40960;
    endfunction

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
    endtask

    task automatic random_regs();
        cfg_write(REG_OFFSET, rv());
        cfg_write(REG_LOW_CUT, rv());
        cfg_write(REG_HIGH_CUT, rv());
        cfg_write(REG_LOW_TRIM, longint'($urandom_range(8192)) - 4096);
        cfg_write(REG_HIGH_TRIM, longint'($urandom_range(8192)) - 4096);
        cfg_write(REG_MODE, $urandom_range(1));
        cfg_write(REG_LEVEL, rv());
    endtask

    initial begin
        sb = new();
        stall_cycles = 0;
        n_samples = 0;
        idle_pct = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        send_word(0, 0, 0, 0, 0, 0);
        send_word(40960, 40960, 40960, 40960, 40960, 40960);
        send_word(-40960, -40960, -40960, -40960, -40960, -40960);
        send_word(65535, -65536, 1, 65535, -65536, 65535);
        send_word(20479, 0, 0, 0, 0, -40960);
        send_word(-20480, 0, 0, 0, 0, -100);
        drain();
        cfg_write(7, 1234);
        cfg_write(REG_MODE, 1);
        cfg_write(REG_LOW_TRIM, 4096);
        cfg_write(REG_HIGH_TRIM, -4096);
        cfg_write(REG_LEVEL, -40960);
        send_word(20479, 0, 0, 0, 0, 0);
        send_word(20480, 0, 0, 0, 0, 0);
        send_word(-1, 0, 0, 0, 0, 40960);
        send_word(12345, 0, 0, 40960, 40960, 40960);
        send_word(0, 0, 0, 20478, -20478, -40960);
        send_word(0, 0, 0, 20480, -20480, 0);
        drain();
        cfg_write(REG_OFFSET, 40960);
        cfg_write(REG_LOW_CUT, 3);
        cfg_write(REG_HIGH_CUT, 0);
        cfg_write(REG_MODE, 0);
        cfg_write(REG_LOW_TRIM, -4096);
        cfg_write(REG_HIGH_TRIM, 4096);
        cfg_write(REG_LEVEL, 40960);
        send_word(0, 0, 0, 0, 0, 0);
        send_word(100, 0, 0, 0, 2, 0);
        send_word(-5, 0, 0, 0, 5, 0);
        send_word(0, 0, 0, 0, 10, -40960);
        drain();
        cfg_write(REG_OFFSET, -65536);
        cfg_write(REG_LOW_CUT, -40960);
        cfg_write(REG_HIGH_CUT, 65535);
        cfg_write(REG_LOW_TRIM, 8191);
        cfg_write(REG_HIGH_TRIM, -8192);
        send_word(0, 0, 0, 40960, 40960, 0);
        send_word(1000, 2000, 3000, -40960, -40960, 0);
        drain();

        for (i = 0; i < 12; i++) begin
            case (i % 4)
                0: idle_pct = 0;
                1: idle_pct = 46;
                2: idle_pct = 0;
                default: idle_pct = 6;
            endcase
            random_regs();
            for (k = 0; k < 45; k++) begin
                if ($urandom_range(7) == 0) begin
                    send_word(rv(), rv(), rv(), 0, 0, rv());
                end else begin
                    send_word(rv(), rv(), rv(), rv(), rv(), rv());
                end
            end
            drain();
        end

        $display("Covered %0d samples, %0d results checked, over fold and wrap settings,",
                 n_samples, sb.checked);
        $display("degenerate and extreme bounds, and sender idling phases.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
